// ----- sv/rwc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replay window check package
// Shared widths, verdict codes and the result type of the anti-replay check.
// ----------------------------------------------------------------------------
package rwc_pkg;

	localparam int unsigned WINDOW    = 64;
	localparam int unsigned DIST_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int unsigned CNT_W     = 32;
	localparam int unsigned IN_DATA_W = 32;
	localparam int unsigned OUT_DATA_W = 8;

	typedef logic [CNT_W-1:0]  counter_t;
	typedef logic [WINDOW-1:0] seen_map_t;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT = 2'd0,
		VERDICT_DUP    = 2'd1,
		VERDICT_OLD    = 2'd2
	} verdict_t;

	typedef struct packed {
		logic     accepted;
		verdict_t verdict;
	} rwc_result_t;

endpackage

// ----- sv/rwc_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replay window state and decision
// Holds the highest counter, the seen flag and the window bitmap, decides the
// verdict for one counter and updates the state in the same cycle.
// ----------------------------------------------------------------------------
module rwc_window (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                check,
	input  rwc_pkg::counter_t   counter,
	output rwc_pkg::rwc_result_t result,
	output logic                any_seen
);
	import rwc_pkg::*;

	counter_t  highest_q;
	logic      any_seen_q;
	seen_map_t map_q;

	counter_t  highest_d;
	seen_map_t map_d;
	counter_t  ahead;
	counter_t  behind;
	verdict_t  verdict;

	always_comb begin
		ahead     = counter - highest_q;
		behind    = highest_q - counter;
		highest_d = highest_q;
		map_d     = map_q;
		verdict   = VERDICT_ACCEPT;
		if (!any_seen_q) begin
			highest_d = counter;
			map_d     = seen_map_t'(1);
		end else if (counter > highest_q) begin
			highest_d = counter;
			if (ahead >= counter_t'(WINDOW)) begin
				map_d = '0;
			end else begin
				map_d = map_q << ahead[DIST_W-1:0];
			end
			map_d[0] = 1'b1;
		end else if (behind >= counter_t'(WINDOW)) begin
			verdict = VERDICT_OLD;
		end else if (map_q[behind[DIST_W-1:0]]) begin
			verdict = VERDICT_DUP;
		end else begin
			map_d[behind[DIST_W-1:0]] = 1'b1;
		end
		result.accepted = (verdict == VERDICT_ACCEPT);
		result.verdict  = verdict;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			highest_q  <= '0;
			any_seen_q <= 1'b0;
			map_q      <= '0;
		end else if (check) begin
			highest_q  <= highest_d;
			any_seen_q <= 1'b1;
			map_q      <= map_d;
		end
	end

	assign any_seen = any_seen_q;

endmodule

// ----- sv/replay_window_check_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replay window check unit
// Receive-side anti-replay check over a sliding window of packet counters.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  s_axis  | in        | tdata[31:0] packet_counter
//  m_axis  | out       | tdata[0] accepted, tdata[2:1] verdict, tdata[7:3] zero
//
//  One transaction per cycle while the output is not stalled: an input register,
//  the compare, subtract and bitmap shift, then the result register.
//  The window state is updated in the cycle the result register is loaded.
//  Reset empties the window; the first counter afterwards is always accepted.
//  A stalled result holds the input register; both stages stay full.
// ----------------------------------------------------------------------------
module replay_window_check_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [rwc_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // packet_counter
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [rwc_pkg::OUT_DATA_W-1:0]     m_axis_tdata   // accepted, verdict
);
	import rwc_pkg::*;

	logic        valid_s1;
	counter_t    counter_s1;
	logic        valid_s2;
	rwc_result_t result_s2;
	rwc_result_t result;
	logic        advance;
	logic        any_seen;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			counter_s1 <= s_axis_tdata[CNT_W-1:0];
		end
	end

	rwc_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.check    (advance),
		.counter  (counter_s1),
		.result   (result),
		.any_seen (any_seen)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(OUT_DATA_W - 3){1'b0}}, result_s2.verdict, result_s2.accepted};

	a_verdict_legal : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[2:1] != 2'd3))
		else $error("verdict code 3 on output");

	a_accept_matches : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] == VERDICT_ACCEPT)))
		else $error("accepted flag disagrees with verdict");

	a_first_accepted : assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !any_seen) |=> (m_axis_tvalid && m_axis_tdata[0]))
		else $error("first counter after reset not accepted");

	a_seen_after_check : assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> any_seen)
		else $error("window still empty after a check");

endmodule

// ----- bench/tb_replay_window_check_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replay window check unit testbench
// Streams packet counters into the anti-replay check and compares every
// verdict with a behavioral window predictor that runs on each transaction
// taken on the input side. The input side sends in bursts with random gaps,
// and the output side stalls on a changing pattern.
// ----------------------------------------------------------------------------
module tb_replay_window_check_unit;
	import rwc_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // packet_counter
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;        // accepted, verdict, zero pad

	counter_t    counter_q[$];
	rwc_result_t due_verdicts[$];

	counter_t  win_hi = '0;
	logic      win_any = 1'b0;
	seen_map_t win_map = '0;
	counter_t  gen_hi = '0;

	int n_sent = 0;
	int n_taken = 0;
	int n_err = 0;
	int n_acc = 0;
	int n_dup = 0;
	int n_old = 0;
	int burst_left = 1;
	int gap_left = 0;
	int rdy_cnt = 0;
	int rdy_mode = 0;

	replay_window_check_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic rwc_result_t window_check(counter_t c);
		logic [CNT_W:0] span;
		verdict_t       v;
		rwc_result_t    r;
		v = VERDICT_ACCEPT;
		if (!win_any) begin
			win_any = 1'b1;
			win_hi = c;
			win_map = '0;
			win_map[0] = 1'b1;
		end else if (c > win_hi) begin
			span = {1'b0, c} - {1'b0, win_hi};
			win_map = (span >= WINDOW) ? '0 : (win_map << span);
			win_hi = c;
			win_map[0] = 1'b1;
		end else begin
			span = {1'b0, win_hi} - {1'b0, c};
			if (span >= WINDOW)
				v = VERDICT_OLD;
			else if (win_map[span[DIST_W-1:0]])
				v = VERDICT_DUP;
			else
				win_map[span[DIST_W-1:0]] = 1'b1;
		end
		r.accepted = (v == VERDICT_ACCEPT);
		r.verdict = v;
		return r;
	endfunction

	function automatic void add_counter(counter_t c);
		counter_q.push_back(c);
		if (c > gen_hi)
			gen_hi = c;
	endfunction

	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			m_axis_tready <= 1'b0;
		end else begin
			if (!(s_axis_tvalid && n_taken < n_sent)) begin
				if (gap_left > 0) begin
					s_axis_tvalid <= 1'b0;
					gap_left--;
				end else if (counter_q.size() == 0) begin
					s_axis_tvalid <= 1'b0;
				end else begin
					s_axis_tdata <= counter_q.pop_front();
					s_axis_tvalid <= 1'b1;
					n_sent++;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
					end
				end
			end
			rdy_cnt++;
			if (rdy_cnt % 50 == 0)
				rdy_mode = $urandom_range(0, 3);
			case (rdy_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= 1'($urandom_range(0, 1));
				2: m_axis_tready <= (rdy_cnt % 3 == 0);
				default: m_axis_tready <= (rdy_cnt % 16) < 8;
			endcase
		end
	end

	always @(posedge clk) begin
		rwc_result_t exp_r;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_verdicts.size() == 0) begin
					$error("result transaction with no verdict pending: tdata=%0h", m_axis_tdata);
					n_err++;
				end else begin
					exp_r = due_verdicts.pop_front();
					if (m_axis_tdata[0] !== exp_r.accepted) begin
						$error("accepted: expected %0d, got %0d", exp_r.accepted, m_axis_tdata[0]);
						n_err++;
					end
					if (m_axis_tdata[2:1] !== exp_r.verdict) begin
						$error("verdict: expected %0d, got %0d", exp_r.verdict, m_axis_tdata[2:1]);
						n_err++;
					end
					if (m_axis_tdata[7:3] !== 5'd0) begin
						$error("pad: expected 0, got %0h", m_axis_tdata[7:3]);
						n_err++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				exp_r = window_check(s_axis_tdata);
				due_verdicts.push_back(exp_r);
				n_taken++;
				case (exp_r.verdict)
					VERDICT_ACCEPT: n_acc++;
					VERDICT_DUP: n_dup++;
					default: n_old++;
				endcase
			end
		end
	end

	initial begin
		int unsigned kind;
		int unsigned step;
		longint unsigned room;
		counter_t start_list[$];
		start_list = '{0, 0, 5, 3, 3, 5, 69, 5, 6, 6, 7, 130, 69, 70, 194, 131, 130};
		foreach (start_list[i])
			add_counter(start_list[i]);
		repeat (1900) begin
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				step = $urandom_range(1, 70);
				if (gen_hi <= 32'hFFFFFFFF - step)
					add_counter(gen_hi + step);
				else
					add_counter(gen_hi - $urandom_range(0, 63));
			end else if (kind < 70) begin
				step = $urandom_range(0, 63);
				add_counter((gen_hi >= step) ? gen_hi - step : 32'd0);
			end else if (kind < 82) begin
				if (gen_hi < 64)
					add_counter(gen_hi);
				else if ($urandom_range(0, 1) == 0 && gen_hi >= 70)
					add_counter(gen_hi - $urandom_range(64, 70));
				else
					add_counter($urandom_range(0, gen_hi - 64));
			end else if (kind < 90) begin
				add_counter($urandom_range(0, gen_hi));
			end else begin
				room = 64'h0000_0000_FFFF_FFFF - gen_hi;
				if (room >= 1024)
					add_counter(gen_hi + $urandom_range(64, 32'(room / 16)));
				else
					add_counter(gen_hi - $urandom_range(0, 63));
			end
		end
		add_counter(32'hFFFFFFFF);
		add_counter(32'hFFFFFFFF);
		add_counter(32'hFFFFFFBF);
		add_counter(32'hFFFFFFC0);
		add_counter(32'd0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (counter_q.size() != 0 || n_taken < n_sent)
			@(posedge clk);
		while (due_verdicts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Checked %0d counters: %0d accepted, %0d duplicates, %0d too old.",
			n_taken, n_acc, n_dup, n_old);
		$display("Highest counter reached %0h with %0d mismatches.", win_hi, n_err);
		if (n_err == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end

endmodule
